// ===== sv/mgm_pkg.sv =====
// ----------------------------------------------------------------------------
// mgm_pkg
// Shared types and constants of the masked 3x3 gray morphology block.
// ----------------------------------------------------------------------------
`default_nettype none

package mgm_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int MIN_DIM = 3;

  // output queue
  localparam int QDEPTH = 3;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 2;

  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef enum logic [CIDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_OP_MODE      = 2'd2,
    REG_KERNEL_MASK  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_DILATE = 1'b0,
    OP_ERODE  = 1'b1
  } op_mode_e;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [11:0] image_width;
    logic [12:0] image_height;
    op_mode_e    op_mode;
    logic [8:0]  kernel_mask;
  } cfg_t;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd2048;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd2048;
  localparam logic [8:0]  RST_KERNEL_MASK  = 9'h1FF;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  // control carried from the address stage to the window stage
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             border;
    logic             row_end;
    logic             frame_end;
    logic [PIX_W-1:0] pixel;
  } s1_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mgm_stream_if.sv =====
// ----------------------------------------------------------------------------
// mgm_stream_if
// Valid/ready stream channels for pixel input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mgm_in_if;
  import mgm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mgm_out_if;
  import mgm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mgm_line_ram.sv =====
// ----------------------------------------------------------------------------
// mgm_line_ram
// One-write, one-read line store with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mgm_ctrl
// Raster counters, drain/tail decisions and line store addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT + 2),
  localparam int ORW = $clog2(MAX_HEIGHT)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mgm_pkg::cfg_t     cfg_i,
  input  wire logic              accept_i,
  input  wire mgm_pkg::in_item_t item_i,
  output logic                   take_o,
  output logic [CW-1:0]          idx_o,
  output logic [7:0]             pix_o,
  output mgm_pkg::s1_ctl_t       s1_o,
  output logic [CW-1:0]          s1_idx_o
);
  import mgm_pkg::*;

  localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int HW = (RW > 13) ? RW : 13;

  logic [CW-1:0]  in_col_q, in_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [ORW-1:0] out_row_q, out_row_d;
  s1_ctl_t        s1_q, s1_d;
  logic [CW-1:0]  s1_idx_q;

  logic [WW-1:0] img_w, w_lim, w_m1;
  logic [HW-1:0] img_h, h_lim, h_m1;
  logic tail, drop, take, emit, in_last_col;
  logic row_end, row_last, frame_end, border;
  logic [PIX_W-1:0] pix;

  always_comb begin
    img_w = WW'(cfg_i.image_width);
    if (img_w < WW'(MIN_DIM)) begin
      w_lim = WW'(MIN_DIM);
    end else if (img_w > WW'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = img_w;
    end
    w_m1 = w_lim - WW'(1);

    img_h = HW'(cfg_i.image_height);
    if (img_h < HW'(MIN_DIM)) begin
      h_lim = HW'(MIN_DIM);
    end else if (img_h > HW'(MAX_HEIGHT)) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = img_h;
    end
    h_m1 = h_lim - HW'(1);
  end

  // tail: whole frame is in, remaining steps only push the last results out
  assign tail = HW'(in_row_q) >= h_lim;
  assign drop = (item_i.cmd == CMD_DRAIN) && !tail;
  assign take = accept_i && !drop;
  assign pix  = tail ? PIX_MIN : item_i.pixel_in;

  assign emit = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign in_last_col = WW'(in_col_q) >= w_m1;

  assign row_end   = WW'(out_col_q) >= w_m1;
  assign row_last  = HW'(out_row_q) >= h_m1;
  assign frame_end = row_end && row_last;
  assign border    = (out_col_q == '0) || (out_row_q == '0) || row_end || row_last;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (in_last_col) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (frame_end) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (row_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    s1_d.valid     = take;
    s1_d.emit      = emit;
    s1_d.border    = border;
    s1_d.row_end   = row_end;
    s1_d.frame_end = frame_end;
    s1_d.pixel     = pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_q      <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      s1_q      <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_idx_q <= in_col_q;
    end
  end

  assign take_o   = take;
  assign idx_o    = in_col_q;
  assign pix_o    = pix;
  assign s1_o     = s1_q;
  assign s1_idx_o = s1_idx_q;

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit && frame_end) |=>
      (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("counters not cleared after frame end");

  a_drop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && drop) |=> $stable(in_col_q) && $stable(in_row_q) &&
      $stable(out_col_q) && $stable(out_row_q) && !s1_q.valid)
    else $error("ignored drain changed state");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && s1_q.emit && s1_q.frame_end) |-> (s1_q.row_end && s1_q.border))
    else $error("frame end without row end");

endmodule

`default_nettype wire

// ===== sv/mgm_window.sv =====
// ----------------------------------------------------------------------------
// mgm_window
// 3x3 window registers and masked max/min of the selected neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_window (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mgm_pkg::cfg_t     cfg_i,
  input  wire mgm_pkg::s1_ctl_t  s1_i,
  input  wire logic [7:0]        top_i,
  input  wire logic [7:0]        mid_i,
  output logic                   push_o,
  output mgm_pkg::out_item_t     item_o
);
  import mgm_pkg::*;

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [PIX_W-1:0] lvl0  [9];
  logic [PIX_W-1:0] lvl1  [5];
  logic [PIX_W-1:0] lvl2  [3];
  logic [PIX_W-1:0] lvl3  [2];
  logic [PIX_W-1:0] ident;
  logic [PIX_W-1:0] best;
  logic             erode;

  function automatic logic [PIX_W-1:0] pick(input logic mn, input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    if (mn) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      win_d[k] = win_q[k];
    end
    if (s1_i.valid) begin
      win_d[0] = win_q[1]; win_d[1] = win_q[2]; win_d[2] = top_i;
      win_d[3] = win_q[4]; win_d[4] = win_q[5]; win_d[5] = mid_i;
      win_d[6] = win_q[7]; win_d[7] = win_q[8]; win_d[8] = s1_i.pixel;
    end
  end

  assign erode = cfg_i.op_mode == OP_ERODE;

  // masked-out neighbors take the neutral value, so an empty mask leaves
  // 0 for dilation and 255 for erosion; reduced as a 4-level tree
  always_comb begin
    ident = erode ? PIX_MAX : PIX_MIN;
    for (int k = 0; k < 9; k++) begin
      lvl0[k] = cfg_i.kernel_mask[k] ? win_d[k] : ident;
    end
    for (int k = 0; k < 4; k++) begin
      lvl1[k] = pick(erode, lvl0[2*k], lvl0[2*k+1]);
    end
    lvl1[4] = lvl0[8];
    lvl2[0] = pick(erode, lvl1[0], lvl1[1]);
    lvl2[1] = pick(erode, lvl1[2], lvl1[3]);
    lvl2[2] = lvl1[4];
    lvl3[0] = pick(erode, lvl2[0], lvl2[1]);
    lvl3[1] = lvl2[2];
    best    = pick(erode, lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  assign push_o           = s1_i.valid && s1_i.emit;
  assign item_o.pixel_out = s1_i.border ? win_d[4] : best;
  assign item_o.row_end   = s1_i.row_end;
  assign item_o.frame_end = s1_i.frame_end;

endmodule

`default_nettype wire

// ===== sv/mgm_out_queue.sv =====
// ----------------------------------------------------------------------------
// mgm_out_queue
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_out_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mgm_pkg::out_item_t item_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output mgm_pkg::out_item_t      item_o,
  output logic [1:0]              count_o
);
  import mgm_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

  out_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              pop;

  assign pop = valid_o && ready_i;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + QPTR_W'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + QPTR_W'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= item_i;
    end
  end

  assign valid_o = count_q != '0;
  assign item_o  = mem_q[head_q];
  assign count_o = count_q;

  // input credit check upstream must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QDEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== sv/masked_3x3_gray_morphology.sv =====
// ----------------------------------------------------------------------------
// masked_3x3_gray_morphology
// Masked 3x3 grayscale dilation/erosion over a raster pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output queue has room; each
//   line store does one read and one write per cycle, so every pixel costs a
//   single memory access slot. A window completes image_width + 1 transactions
//   after its own pixel; its result is registered into the output queue.
// Reset: counters, window, config and queue clear at once; the line stores
//   keep their contents and are not swept, no wait after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_3x3_gray_morphology #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  mgm_in_if.sink           in_i,
  mgm_out_if.source        out_o
);
  import mgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t cfg_q, cfg_d;

  logic             take;
  logic [CW-1:0]    idx, s1_idx;
  logic [PIX_W-1:0] pix, mid_rd, up_rd, top_val;
  s1_ctl_t          s1;
  logic             fwd_q, fwd_d;
  logic [PIX_W-1:0] fwd_data_q;
  logic             push;
  out_item_t        res_item;
  logic [1:0]       q_count;
  logic [2:0]       occupancy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[11:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i;
        REG_OP_MODE:      cfg_d.op_mode      = op_mode_e'(cfg_data_i[0]);
        REG_KERNEL_MASK:  cfg_d.kernel_mask  = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= RST_IMAGE_WIDTH;
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
      cfg_q.op_mode      <= OP_DILATE;
      cfg_q.kernel_mask  <= RST_KERNEL_MASK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // results in flight plus queued must fit the queue
  assign occupancy  = {1'b0, q_count} + {2'b00, s1.valid && s1.emit};
  assign in_i.ready = occupancy < 3'(QDEPTH);

  mgm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_i.valid && in_i.ready),
    .item_i   (in_i.data),
    .take_o   (take),
    .idx_o    (idx),
    .pix_o    (pix),
    .s1_o     (s1),
    .s1_idx_o (s1_idx)
  );

  // middle row: read old value and write the new pixel in the same cycle
  mgm_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (take),
    .waddr_i (idx),
    .wdata_i (pix),
    .re_i    (take),
    .raddr_i (idx),
    .rdata_o (mid_rd)
  );

  // upper row takes the old middle value in the cycle after it is read
  mgm_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1.valid),
    .waddr_i (s1_idx),
    .wdata_i (mid_rd),
    .re_i    (take),
    .raddr_i (idx),
    .rdata_o (up_rd)
  );

  // a read of the entry being written back this cycle (column 0 right
  // after a frame end) must see the new value
  assign fwd_d = take && s1.valid && (s1_idx == idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd_d) begin
      fwd_data_q <= mid_rd;
    end
  end

  assign top_val = fwd_q ? fwd_data_q : up_rd;

  mgm_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .s1_i   (s1),
    .top_i  (top_val),
    .mid_i  (mid_rd),
    .push_o (push),
    .item_o (res_item)
  );

  mgm_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (res_item),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .item_o  (out_o.data),
    .count_o (q_count)
  );

endmodule

`default_nettype wire

// ===== test/morph_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morph_result_checker
// Watches the pixel and result channels and the register port, keeps its own
// line stores, window and counters, predicts every result of the masked 3x3
// morphology and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------

module morph_result_checker #(
  parameter int MAX_W = 2048,
  parameter int MAX_H = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  mgm_in_if           pix_i,
  mgm_out_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output logic        frame_open_o
);
  import mgm_pkg::*;

  logic [11:0] width_r;
  logic [12:0] height_r;
  op_mode_e    mode_r;
  logic [8:0]  mask_r;

  logic [PIX_W-1:0] upper_mem [MAX_W];
  logic [PIX_W-1:0] mid_mem   [MAX_W];
  logic [PIX_W-1:0] win       [9];
  int unsigned      in_col, in_row, out_col, out_row;
  int unsigned      n_results;

  out_item_t out_pixels_due [$];

  // line stores are never cleared; entries read before being written only
  // ever land in window positions that no result uses
  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_mem[i] = PIX_MIN;
      mid_mem[i]   = PIX_MIN;
    end
    fail_count_o = 0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] window_pick();
    logic [PIX_W-1:0] best;
    best = (mode_r == OP_ERODE) ? PIX_MAX : PIX_MIN;
    for (int k = 0; k < 9; k++) begin
      if (mask_r[k]) begin
        if (mode_r == OP_ERODE) begin
          if (win[k] < best) best = win[k];
        end else begin
          if (win[k] > best) best = win[k];
        end
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count_o < 100) $display("MISMATCH at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic morph_step(in_item_t px);
    int unsigned      w, h, idx;
    logic             tail, emit, rend, fend, border;
    logic [PIX_W-1:0] p, top_v, mid_v;
    out_item_t        r;
    w    = clamp_dim(width_r, MAX_W);
    h    = clamp_dim(height_r, MAX_H);
    tail = (in_row >= h);
    // a drain only counts once the whole frame is in
    if (px.cmd == CMD_DRAIN && !tail) return;
    p = tail ? PIX_MIN : px.pixel_in;

    idx = (in_col < MAX_W) ? in_col : MAX_W - 1;
    top_v          = upper_mem[idx];
    mid_v          = mid_mem[idx];
    upper_mem[idx] = mid_v;
    mid_mem[idx]   = p;

    win[0] = win[1]; win[1] = win[2]; win[2] = top_v;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid_v;
    win[6] = win[7]; win[7] = win[8]; win[8] = p;

    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!emit) return;

    rend   = (out_col + 1 >= w);
    fend   = rend && (out_row + 1 >= h);
    border = (out_col == 0) || (out_row == 0) || rend || (out_row + 1 >= h);
    r.pixel_out = border ? win[4] : window_pick();
    r.row_end   = rend;
    r.frame_end = fend;
    out_pixels_due = {out_pixels_due, r};

    if (fend) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (rend) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (out_pixels_due.size() == 0) begin
      report_mismatch($sformatf(
        "result %0d not expected: pixel %0d row_end %0b frame_end %0b",
        n_results, got.pixel_out, got.row_end, got.frame_end));
    end else begin
      want = out_pixels_due.pop_front();
      if (got.pixel_out !== want.pixel_out || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end) begin
        report_mismatch($sformatf(
          "result %0d: pixel %0d/%0d row_end %0b/%0b frame_end %0b/%0b (got/exp)",
          n_results, got.pixel_out, want.pixel_out, got.row_end, want.row_end,
          got.frame_end, want.frame_end));
      end
    end
    n_results++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_r  = RST_IMAGE_WIDTH;
      height_r = RST_IMAGE_HEIGHT;
      mode_r   = OP_DILATE;
      mask_r   = RST_KERNEL_MASK;
      for (int k = 0; k < 9; k++) win[k] = PIX_MIN;
      in_col    = 0;
      in_row    = 0;
      out_col   = 0;
      out_row   = 0;
      n_results = 0;
      out_pixels_due.delete();
      pending_o    = 0;
      frame_open_o = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:  width_r  = cfg_data_i[11:0];
          REG_IMAGE_HEIGHT: height_r = cfg_data_i;
          REG_OP_MODE:      mode_r   = op_mode_e'(cfg_data_i[0]);
          REG_KERNEL_MASK:  mask_r   = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) morph_step(pix_i.data);
      if (res_i.valid && res_i.ready) check_result(res_i.data);
      pending_o    = out_pixels_due.size();
      frame_open_o = (in_col != 0) || (in_row != 0);
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for masked_3x3_gray_morphology: a partial frame under the reset
// registers, small directed frames, frames with undersized registers, then
// random frames with drain noise, short tails and mid-frame register changes.
// Sender bursts and receiver stalls are random; the checker does the scoring.
// ----------------------------------------------------------------------------

module tb_top;
  import mgm_pkg::*;

  localparam int          MAX_W       = 2048;
  localparam int          MAX_H       = 4096;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RANDOM_ITEMS = 950;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_PATTERN
  } rdy_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [12:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  logic        frame_open;

  int unsigned burst_left;
  int unsigned random_items;
  int unsigned cur_w, cur_h;
  int unsigned cycle_cnt;

  rdy_mode_e   ready_mode;
  int unsigned ready_hold;
  logic [7:0]  stall_pat;

  mgm_in_if  pix_in_if ();
  mgm_out_if pix_out_if ();

  masked_3x3_gray_morphology #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in_if),
    .out_o      (pix_out_if)
  );

  morph_result_checker #(
    .MAX_W (MAX_W),
    .MAX_H (MAX_H)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_i        (pix_in_if),
    .res_i        (pix_out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frame_open_o (frame_open)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("masked_3x3_gray_morphology test failed");
      $finish;
    end
  end

  // receiver: stall mode and pattern are redrawn whenever the hold counter runs out
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode = rdy_mode_e'($urandom_range(0, 3));
      ready_hold = $urandom_range(20, 200);
      stall_pat  = 8'($urandom_range(1, 255));
    end
    ready_hold--;
    case (ready_mode)
      RDY_ALWAYS: pix_out_if.ready <= 1'b1;
      RDY_HALF:   pix_out_if.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: pix_out_if.ready <= ($urandom_range(0, 3) == 0);
      default:    pix_out_if.ready <= stall_pat[ready_hold % 8];
    endcase
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [8:0] rand_mask();
    case ($urandom_range(0, 5))
      0:       return 9'h000;
      1:       return 9'h1FF;
      2:       return 9'(1 << $urandom_range(0, 8));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic int unsigned dim_eff(int unsigned v, int unsigned hi);
    return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  task automatic send_item(input cmd_e c, input logic [7:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        pix_in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    pix_in_if.valid         <= 1'b1;
    pix_in_if.data.cmd      <= c;
    pix_in_if.data.pixel_in <= p;
    @(posedge clk_i);
    while (!pix_in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the sender until every predicted result is out and the pipe is empty
  task automatic settle();
    pix_in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int unsigned v);
    cfg_idx  <= r;
    cfg_data <= 13'(v);
    cfg_we   <= 1'b1;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // pushes act as drains once the frame is in, so this always ends the frame
  task automatic close_frame();
    while (frame_open) send_item(CMD_PUSH, rand8());
  endtask

  task automatic set_frame(input int unsigned wv, input int unsigned hv,
                           input op_mode_e op, input logic [8:0] mask);
    close_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, wv);
    write_reg(REG_IMAGE_HEIGHT, hv);
    write_reg(REG_OP_MODE, op);
    write_reg(REG_KERNEL_MASK, mask);
    cur_w = wv;
    cur_h = hv;
  endtask

  task automatic run_frame(input bit may_reshape);
    int unsigned w, h, n, tail_len;
    bit          reshaped;
    w        = dim_eff(cur_w, MAX_W);
    h        = dim_eff(cur_h, MAX_H);
    reshaped = 1'b0;
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(0, 15) == 0) send_item(CMD_DRAIN, rand8());
      if (may_reshape && !reshaped && $urandom_range(0, 99) == 0) begin
        settle();
        // width only shrinks mid frame: wider rows would read line store
        // entries this frame never wrote
        cur_w = $urandom_range(0, dim_eff(cur_w, MAX_W));
        cur_h = $urandom_range(0, h + 3);
        write_reg(REG_IMAGE_WIDTH, cur_w);
        write_reg(REG_IMAGE_HEIGHT, cur_h);
        write_reg(REG_OP_MODE, $urandom_range(0, 1));
        write_reg(REG_KERNEL_MASK, rand_mask());
        reshaped = 1'b1;
      end
      send_item(CMD_PUSH, rand8());
      random_items++;
    end
    if (reshaped) begin
      close_frame();
    end else begin
      tail_len = w + 1;
      if ($urandom_range(0, 11) == 0) tail_len = $urandom_range(0, w);
      repeat (tail_len) begin
        if ($urandom_range(0, 7) == 0) send_item(CMD_PUSH, rand8());
        else send_item(CMD_DRAIN, rand8());
        random_items++;
      end
    end
    if ($urandom_range(0, 7) == 0) settle();
  endtask

  initial begin
    clk_i                   = 1'b0;
    rst_ni                  = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = REG_IMAGE_WIDTH;
    cfg_data                = '0;
    pix_in_if.valid         = 1'b0;
    pix_in_if.data          = '0;
    pix_out_if.ready        = 1'b0;
    burst_left              = 0;
    random_items            = 0;
    cycle_cnt               = 0;
    ready_hold              = 0;
    cur_w                   = RST_IMAGE_WIDTH;
    cur_h                   = RST_IMAGE_HEIGHT;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: part of a row into a full-width frame, then shrink
    // the width under the column counter so the column bound is passed
    repeat (40) send_item(CMD_PUSH, rand8());
    settle();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 4);
    cur_w = 3;
    cur_h = 4;
    close_frame();

    // 3x3 checkerboard, center dark: full-mask dilation, then empty-mask
    // erosion; early drains are ignored, a push in the tail is a drain
    for (int f = 0; f < 2; f++) begin
      if (f == 0) set_frame(3, 3, OP_DILATE, 9'h1FF);
      else set_frame(3, 3, OP_ERODE, 9'h000);
      send_item(CMD_DRAIN, 8'hA5);
      for (int k = 0; k < 9; k++) begin
        if (k == 4 && f == 0) send_item(CMD_DRAIN, 8'h3C);
        send_item(CMD_PUSH, (k % 2 != 0) ? PIX_MAX : PIX_MIN);
      end
      send_item(CMD_DRAIN, 8'h00);
      send_item(CMD_PUSH, 8'h5A);
      send_item(CMD_DRAIN, 8'hFF);
      send_item(CMD_DRAIN, 8'h00);
    end

    // undersized registers clamp to the smallest frame
    set_frame(0, 0, OP_ERODE, 9'h1FF);
    run_frame(1'b0);
    set_frame(2, 1, OP_DILATE, 9'h000);
    run_frame(1'b0);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       cur_w = $urandom_range(0, 2);
        1:       cur_w = $urandom_range(13, 40);
        default: cur_w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       cur_h = $urandom_range(0, 2);
        1:       cur_h = $urandom_range(9, 16);
        default: cur_h = $urandom_range(3, 8);
      endcase
      set_frame(cur_w, cur_h, op_mode_e'($urandom_range(0, 1)), rand_mask());
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
    end

    settle();
    repeat (12) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("masked_3x3_gray_morphology test passed");
    end else begin
      $display("masked_3x3_gray_morphology test failed");
    end
    $finish;
  end

endmodule
